// ===== design/uartq_pkg.sv =====
// Package with the types and constants of the UART receive event queue.
`timescale 1ns / 1ps
package uartq_pkg;

  localparam int SLOTS        = 64;
  localparam int PACKET_BYTES = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int USED_W       = $clog2(SLOTS + 1);
  localparam int LEN_W        = $clog2(PACKET_BYTES + 1);
  localparam int BYTES_DEPTH  = SLOTS * PACKET_BYTES;
  localparam int BADDR_W      = $clog2(BYTES_DEPTH);

  localparam logic [3:0] ERR_FRAMING = 4'b0001;
  localparam logic [3:0] ERR_NOISE   = 4'b0010;
  localparam logic [3:0] ERR_OVERRUN = 4'b0100;
  localparam logic [3:0] ERR_LOST    = 4'b1000;

  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_KICK  = 2'd1,
    CMD_GET   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_HALT      = 3'd1,
    KIND_ERRORS    = 3'd2,
    KIND_REJECT    = 3'd3,
    KIND_CLR_OK    = 3'd4,
    KIND_CLR_REFUS = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FN,
    S_BYTE,
    S_OVR,
    S_HREAD,
    S_DECIDE,
    S_BRD,
    S_BWT,
    S_LOST
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       framing_error;
    logic       noise_error;
    logic       overrun_error;
    logic       flash_select_active;
    logic       endpoint_busy;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    logic       last;
  } out_t;

  typedef struct packed {
    logic             is_error;
    logic [LEN_W-1:0] length;
    logic [3:0]       err_bits;
  } meta_t;

endpackage

// ===== design/uartq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module uartq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/uart_rx_event_coalescing_queue.sv =====
// UART receive event coalescing queue with slot memories and a sequencer.
// Each packet byte sent is read from the slot byte memory and then loaded into
// the output register. A pending lost event is queued as an error entry after
// a packet. Output stalls hold the sequencer, and input is stalled until idle.
// Reset clears the head, tail, fill count, lost flag, output valid and the sequencer at once;
// the slot memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module uart_rx_event_coalescing_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uartq_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uartq_pkg::out_t  out_o
);

  uartq_pkg::state_e state_q, state_d;
  uartq_pkg::in_t    item_q, item_d;

  logic [uartq_pkg::SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [uartq_pkg::USED_W-1:0] used_q, used_d;
  logic                         lost_q, lost_d;
  uartq_pkg::meta_t             tmeta_q, tmeta_d;
  logic [uartq_pkg::LEN_W-1:0]  cnt_q, cnt_d, len_q, len_d;
  logic                         out_valid_q, out_valid_d;
  uartq_pkg::out_t              out_q, out_d;

  logic                   op_err, op_byte, do_pop, clr_lost, emit, out_free;
  logic [3:0]             op_bits;
  uartq_pkg::kind_e       emit_kind;
  logic [7:0]             emit_payload;
  logic                   emit_last;
  logic                   meta_re, byte_re, meta_we, byte_we;
  uartq_pkg::meta_t       meta_rd, meta_wd;
  logic [uartq_pkg::BADDR_W-1:0] byte_waddr, byte_raddr;
  logic [7:0]             byte_rd;
  logic                   queue_empty, head_err, last_byte;

  function automatic logic [uartq_pkg::SLOT_W-1:0] next_slot(
    input logic [uartq_pkg::SLOT_W-1:0] s
  );
    return (s == uartq_pkg::SLOT_W'(uartq_pkg::SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [uartq_pkg::BADDR_W-1:0] byte_addr(
    input logic [uartq_pkg::SLOT_W-1:0] s,
    input logic [uartq_pkg::LEN_W-1:0]  i
  );
    return uartq_pkg::BADDR_W'(uartq_pkg::BADDR_W'(s) *
                               uartq_pkg::BADDR_W'(uartq_pkg::PACKET_BYTES)) +
           uartq_pkg::BADDR_W'(i);
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign queue_empty = (used_q == '0);
  assign head_err    = meta_rd.is_error;
  assign last_byte   = (cnt_q == len_q - 1'b1);
  assign in_stall_o  = (state_q != uartq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      uartq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_i.cmd)
            uartq_pkg::CMD_RX:   state_d = in_i.flash_select_active ?
                                           uartq_pkg::S_IDLE : uartq_pkg::S_FN;
            uartq_pkg::CMD_KICK: state_d = in_i.endpoint_busy ?
                                           uartq_pkg::S_IDLE : uartq_pkg::S_HREAD;
            default:             state_d = uartq_pkg::S_HREAD;
          endcase
        end
      end
      uartq_pkg::S_FN:    state_d = uartq_pkg::S_BYTE;
      uartq_pkg::S_BYTE:  state_d = uartq_pkg::S_OVR;
      uartq_pkg::S_OVR:   state_d = item_q.endpoint_busy ?
                                    uartq_pkg::S_IDLE : uartq_pkg::S_HREAD;
      uartq_pkg::S_HREAD: state_d = uartq_pkg::S_DECIDE;
      uartq_pkg::S_DECIDE: begin
        case (item_q.cmd)
          uartq_pkg::CMD_GET: begin
            if (out_free) state_d = uartq_pkg::S_IDLE;
          end
          uartq_pkg::CMD_CLEAR: begin
            if (out_free) begin
              state_d = (!queue_empty && !head_err) ? uartq_pkg::S_BRD :
                                                      uartq_pkg::S_IDLE;
            end
          end
          default: begin
            if (queue_empty) begin
              state_d = uartq_pkg::S_IDLE;
            end else if (!head_err) begin
              state_d = uartq_pkg::S_BRD;
            end else if (out_free) begin
              state_d = uartq_pkg::S_IDLE;
            end
          end
        endcase
      end
      uartq_pkg::S_BRD: state_d = uartq_pkg::S_BWT;
      uartq_pkg::S_BWT: begin
        if (out_free) begin
          if (!last_byte)  state_d = uartq_pkg::S_BRD;
          else if (lost_q) state_d = uartq_pkg::S_LOST;
          else             state_d = uartq_pkg::S_IDLE;
        end
      end
      uartq_pkg::S_LOST: state_d = uartq_pkg::S_IDLE;
      default:           state_d = uartq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_d       = item_q;
    op_err       = 1'b0;
    op_bits      = '0;
    op_byte      = 1'b0;
    do_pop       = 1'b0;
    clr_lost     = 1'b0;
    emit         = 1'b0;
    emit_kind    = uartq_pkg::KIND_BYTE;
    emit_payload = '0;
    emit_last    = 1'b1;
    meta_re      = 1'b0;
    byte_re      = 1'b0;
    cnt_d        = cnt_q;
    len_d        = len_q;
    case (state_q)
      uartq_pkg::S_IDLE: begin
        if (in_valid_i) item_d = in_i;
      end
      uartq_pkg::S_FN: begin
        op_err  = item_q.framing_error || item_q.noise_error;
        op_bits = (item_q.framing_error ? uartq_pkg::ERR_FRAMING : 4'b0) |
                  (item_q.noise_error ? uartq_pkg::ERR_NOISE : 4'b0);
      end
      uartq_pkg::S_BYTE: op_byte = item_q.rx_valid;
      uartq_pkg::S_OVR: begin
        op_err  = item_q.overrun_error;
        op_bits = uartq_pkg::ERR_OVERRUN;
      end
      uartq_pkg::S_HREAD: meta_re = 1'b1;
      uartq_pkg::S_DECIDE: begin
        cnt_d = '0;
        len_d = meta_rd.length;
        case (item_q.cmd)
          uartq_pkg::CMD_GET: begin
            emit = out_free;
            if (!queue_empty && head_err) begin
              emit_kind    = uartq_pkg::KIND_ERRORS;
              emit_payload = {4'b0, meta_rd.err_bits};
              do_pop       = out_free;
            end else begin
              emit_kind = uartq_pkg::KIND_REJECT;
            end
          end
          uartq_pkg::CMD_CLEAR: begin
            emit = out_free;
            if (queue_empty || !head_err) begin
              emit_kind = uartq_pkg::KIND_CLR_OK;
              emit_last = queue_empty;
            end else begin
              emit_kind = uartq_pkg::KIND_CLR_REFUS;
            end
          end
          default: begin
            emit      = !queue_empty && head_err && out_free;
            emit_kind = uartq_pkg::KIND_HALT;
          end
        endcase
      end
      uartq_pkg::S_BRD: byte_re = 1'b1;
      uartq_pkg::S_BWT: begin
        emit         = out_free;
        emit_kind    = uartq_pkg::KIND_BYTE;
        emit_payload = byte_rd;
        emit_last    = last_byte;
        do_pop       = out_free && last_byte;
        cnt_d        = out_free ? cnt_q + 1'b1 : cnt_q;
      end
      uartq_pkg::S_LOST: begin
        clr_lost = 1'b1;
        op_err   = 1'b1;
        op_bits  = uartq_pkg::ERR_LOST;
      end
      default: ;
    endcase
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    used_d     = used_q;
    lost_d     = clr_lost ? 1'b0 : lost_q;
    tmeta_d    = tmeta_q;
    meta_we    = 1'b0;
    byte_we    = 1'b0;
    byte_waddr = byte_addr(tail_q, tmeta_q.length);
    if (do_pop) begin
      head_d = next_slot(head_q);
      used_d = used_q - 1'b1;
    end
    if (op_err) begin
      if (!queue_empty && tmeta_q.is_error) begin
        tmeta_d.err_bits = tmeta_q.err_bits | op_bits;
        meta_we          = 1'b1;
      end else if (used_q >= uartq_pkg::USED_W'(uartq_pkg::SLOTS)) begin
        lost_d = 1'b1;
      end else begin
        tail_d           = queue_empty ? head_q : next_slot(tail_q);
        used_d           = used_q + 1'b1;
        tmeta_d.is_error = 1'b1;
        tmeta_d.err_bits = op_bits;
        meta_we          = 1'b1;
      end
    end else if (op_byte) begin
      if (!queue_empty && !tmeta_q.is_error &&
          tmeta_q.length < uartq_pkg::LEN_W'(uartq_pkg::PACKET_BYTES)) begin
        tmeta_d.length = tmeta_q.length + 1'b1;
        meta_we        = 1'b1;
        byte_we        = 1'b1;
      end else if (used_q >= uartq_pkg::USED_W'(uartq_pkg::SLOTS)) begin
        lost_d = 1'b1;
      end else begin
        tail_d           = queue_empty ? head_q : next_slot(tail_q);
        used_d           = used_q + 1'b1;
        tmeta_d.is_error = 1'b0;
        tmeta_d.length   = uartq_pkg::LEN_W'(1);
        meta_we          = 1'b1;
        byte_we          = 1'b1;
        byte_waddr       = byte_addr(tail_d, '0);
      end
    end
    meta_wd = tmeta_d;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d   = 1'b1;
      out_d.kind    = emit_kind;
      out_d.payload = emit_payload;
      out_d.last    = emit_last;
    end
  end

  assign byte_raddr = byte_addr(head_q, cnt_q);

  uartq_ram #(
    .WIDTH($bits(uartq_pkg::meta_t)),
    .DEPTH(uartq_pkg::SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (tail_d),
    .wdata_i (meta_wd),
    .re_i    (meta_re),
    .raddr_i (head_q),
    .rdata_o (meta_rd)
  );

  uartq_ram #(
    .WIDTH(8),
    .DEPTH(uartq_pkg::BYTES_DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (item_q.rx_data),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uartq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    tmeta_q <= tmeta_d;
    cnt_q   <= cnt_d;
    len_q   <= len_d;
    out_q   <= out_d;
  end

endmodule
